// ----- hdl/stv_pkg.sv -----
`timescale 1ns / 1ps
// Package for the speaker timeline range vote block.
// Sizes, derived widths, request mode codes and the segment record type.
package stv_pkg;

  localparam int ENTRIES   = 512;
  localparam int SPEAKERS  = 16;
  localparam int TIME_BITS = 40;

  localparam int SPK_W     = 5;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int FILL_W    = $clog2(ENTRIES + 1);
  localparam int SPK_IDX_W = $clog2(SPEAKERS);
  localparam int CNT_MAX   = (ENTRIES > SPEAKERS) ? ENTRIES : SPEAKERS;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);
  localparam int TOT_W     = (TIME_BITS + 9 > 64) ? 64 : TIME_BITS + 9;

  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_PENDING = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [SPK_W-1:0] SPK_UNKNOWN = '1;

  typedef struct packed {
    logic [TIME_BITS-1:0] from_ms;
    logic [TIME_BITS-1:0] end_ms;
    logic [SPK_W-1:0]     speaker;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

endpackage

// ----- hdl/stv_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module stv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/speaker_timeline_range_vote.sv -----
`timescale 1ns / 1ps
// Top level of the speaker timeline range vote block.
// Uses stv_pkg and two stv_ram instances (segment ring, speaker totals).
//
// Append and set-pending requests complete in the accept cycle; busy stays low.
// A query walks the filled segment entries one entry per cycle, then the pending
// segment, drains the accumulation, then sweeps the totals one speaker per cycle.
// Empty or disabled queries answer next cycle.
// The result is strobed on done_o for one cycle; the receiver cannot stall it.
// Reset (async, active low) clears control state only; the RAMs keep their
// contents and the fill count keeps unwritten entries from being read.
module speaker_timeline_range_vote (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode_i,
  input  logic [stv_pkg::TIME_BITS-1:0]  from_ms_i,
  input  logic [stv_pkg::TIME_BITS-1:0]  end_ms_i,
  input  logic signed [stv_pkg::SPK_W-1:0] speaker_i,
  output logic                           done_o,
  output logic signed [stv_pkg::SPK_W-1:0] best_speaker_o
);
  import stv_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEG   = 3'd1;
  localparam logic [2:0] ST_PEND  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ARG   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       enabled_q;
  logic [IDX_W-1:0]  slot_q;
  logic [FILL_W-1:0] filled_q;
  logic [TIME_BITS-1:0] pend_start_q;
  logic [SPK_W-1:0]     pend_spk_q;
  logic [TIME_BITS-1:0] lo_q, hi_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic a_vld_q, a_vld_d, a_pend_q, a_pend_d;
  logic b_vld_q;
  logic [TIME_BITS-1:0] b_amt_q;
  logic [SPK_IDX_W-1:0] b_spk_q;
  logic f_vld_q;
  logic [SPK_IDX_W-1:0] f_spk_q;
  logic [TOT_W-1:0]     f_dat_q;
  logic [SPEAKERS-1:0]  tvld_q;

  logic g_vld_q, g_vld_d, g_tv_q;
  logic [SPK_IDX_W-1:0] g_idx_q;
  logic [TOT_W-1:0]     best_tot_q, best_tot_d;
  logic [SPK_IDX_W-1:0] best_idx_q, best_idx_d;
  logic                 best_fnd_q, best_fnd_d;

  logic done_q;
  logic [SPK_W-1:0] result_q;

  logic acc, acc_app, acc_qry, qry_quick;
  seg_t wr_seg, rd_seg;
  logic [SEG_W-1:0] rd_raw;

  logic [TIME_BITS-1:0] s_a, e_a, os_a, oe_a;
  logic [SPK_W-1:0]     spk_a;
  logic                 in_rng_a;
  logic [SPK_IDX_W-1:0] spk_idx_a;

  logic [TOT_W-1:0] tot_rdata, tot_in, tot_sat;
  logic [TOT_W:0]   tot_sum;
  logic [SPK_IDX_W-1:0] tot_raddr;

  assign busy    = (state_q != ST_IDLE);
  assign acc     = start && !busy;
  assign acc_app = acc && (mode_i == MODE_APPEND) && (end_ms_i > from_ms_i);
  assign acc_qry = acc && (mode_i == MODE_QUERY);
  assign qry_quick = !enabled_q || (end_ms_i <= from_ms_i);

  assign wr_seg = '{from_ms: from_ms_i, end_ms: end_ms_i, speaker: speaker_i};
  assign rd_seg = seg_t'(rd_raw);

  stv_ram #(.WIDTH(SEG_W), .DEPTH(ENTRIES)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (acc_app),
    .waddr_i (slot_q),
    .wdata_i (wr_seg),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rd_raw)
  );

  // stage A: overlap of one segment (or the pending one) with the range
  always_comb begin
    s_a   = a_pend_q ? pend_start_q : rd_seg.from_ms;
    e_a   = a_pend_q ? hi_q : rd_seg.end_ms;
    spk_a = a_pend_q ? pend_spk_q : rd_seg.speaker;
    os_a  = (s_a > lo_q) ? s_a : lo_q;
    oe_a  = (e_a < hi_q) ? e_a : hi_q;
    in_rng_a  = !spk_a[SPK_W-1] && (32'(spk_a[SPK_W-2:0]) < SPEAKERS);
    spk_idx_a = SPK_IDX_W'(spk_a[SPK_W-2:0]);
  end

  assign tot_raddr = (state_q == ST_ARG) ? cnt_q[SPK_IDX_W-1:0] : spk_idx_a;

  // stage B: saturating add with one-deep forwarding of the last write
  always_comb begin
    if (f_vld_q && (f_spk_q == b_spk_q)) begin
      tot_in = f_dat_q;
    end else if (tvld_q[b_spk_q]) begin
      tot_in = tot_rdata;
    end else begin
      tot_in = '0;
    end
    tot_sum = {1'b0, tot_in} + (TOT_W + 1)'(b_amt_q);
    tot_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
  end

  stv_ram #(.WIDTH(TOT_W), .DEPTH(SPEAKERS)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (b_vld_q),
    .waddr_i (b_spk_q),
    .wdata_i (tot_sat),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  // argmax compare, strictly greater keeps the lowest id on ties
  always_comb begin
    best_tot_d = best_tot_q;
    best_idx_d = best_idx_q;
    best_fnd_d = best_fnd_q;
    if (g_vld_q && g_tv_q && (tot_rdata > best_tot_q)) begin
      best_tot_d = tot_rdata;
      best_idx_d = g_idx_q;
      best_fnd_d = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    a_vld_d  = 1'b0;
    a_pend_d = 1'b0;
    g_vld_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (acc_qry && !qry_quick) begin
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        if (cnt_q == CNT_W'(filled_q)) begin
          state_d = ST_PEND;
        end else begin
          a_vld_d = 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_PEND: begin
        a_vld_d  = 1'b1;
        a_pend_d = 1'b1;
        state_d  = ST_DRAIN;
      end
      ST_DRAIN: begin
        cnt_d = '0;
        if (!a_vld_q && !b_vld_q) begin
          state_d = ST_ARG;
        end
      end
      ST_ARG: begin
        g_vld_d = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SPEAKERS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      enabled_q    <= 1'b0;
      slot_q       <= '0;
      filled_q     <= '0;
      pend_start_q <= '0;
      pend_spk_q   <= SPK_UNKNOWN;
      cnt_q        <= '0;
      a_vld_q      <= 1'b0;
      a_pend_q     <= 1'b0;
      b_vld_q      <= 1'b0;
      f_vld_q      <= 1'b0;
      tvld_q       <= '0;
      g_vld_q      <= 1'b0;
      best_fnd_q   <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      a_vld_q  <= a_vld_d;
      a_pend_q <= a_pend_d;
      g_vld_q  <= g_vld_d;
      b_vld_q  <= a_vld_q && (oe_a > os_a) && in_rng_a;
      f_vld_q  <= b_vld_q;
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      if (acc_app) begin
        slot_q <= (slot_q == IDX_W'(ENTRIES - 1)) ? '0 : slot_q + 1'b1;
        if (filled_q != FILL_W'(ENTRIES)) begin
          filled_q <= filled_q + 1'b1;
        end
      end
      if (acc && (mode_i == MODE_PENDING)) begin
        pend_start_q <= from_ms_i;
        pend_spk_q   <= speaker_i;
      end
      if (acc_qry) begin
        tvld_q     <= '0;
        best_fnd_q <= 1'b0;
      end else begin
        if (b_vld_q) begin
          tvld_q[b_spk_q] <= 1'b1;
        end
        best_fnd_q <= best_fnd_d;
      end
      done_q <= (acc_qry && qry_quick) || (state_q == ST_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    b_amt_q <= oe_a - os_a;
    b_spk_q <= spk_idx_a;
    f_spk_q <= b_spk_q;
    f_dat_q <= tot_sat;
    g_idx_q <= cnt_q[SPK_IDX_W-1:0];
    g_tv_q  <= tvld_q[cnt_q[SPK_IDX_W-1:0]];
    if (acc_qry) begin
      lo_q       <= from_ms_i;
      hi_q       <= end_ms_i;
      best_tot_q <= '0;
      best_idx_q <= '0;
    end else begin
      best_tot_q <= best_tot_d;
      best_idx_q <= best_idx_d;
    end
    if (acc_qry) begin
      result_q <= SPK_UNKNOWN;
    end else if (state_q == ST_FIN) begin
      result_q <= best_fnd_d ? SPK_W'(best_idx_d) : SPK_UNKNOWN;
    end
  end

  assign done_o         = done_q;
  assign best_speaker_o = result_q;

  a_b_from_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> $past(a_vld_q))
    else $error("accumulate stage active without overlap stage");

  a_arg_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ARG) |-> (!a_vld_q && !b_vld_q))
    else $error("totals sweep started before accumulation drained");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FIN || (start && !busy && mode_i == MODE_QUERY)))
    else $error("result strobe without query");

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FILL_W'(ENTRIES))
    else $error("fill count beyond ring depth");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEG) |-> !(a_vld_q && a_pend_q))
    else $error("pending request issued during segment walk");

endmodule
